>>> hdl/plu_pkg.sv
`default_nettype none

package plu_pkg;

   // node values and the interior count
   localparam int VALUE_BITS_DEF = 16;
   localparam int MAX_ADDED_DEF  = 30;

   // width of the interior count register, interior counters and divisor
   localparam int CNT_W = 5;

   localparam logic [CNT_W-1:0] ADDED_RESET = CNT_W'(4);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT,
      ST_TAIL
   } state_type;

endpackage

`default_nettype wire

>>> hdl/plu_floor_div.sv
`default_nettype none

// bit-serial restoring divider, signed dividend, floor rounding
module plu_floor_div #(
   parameter int DATA_W = plu_pkg::VALUE_BITS_DEF + 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           go,
   input  wire logic signed [DATA_W-1:0]       num,
   input  wire logic [plu_pkg::CNT_W-1:0]      den,
   output logic                                done,
   output logic signed [DATA_W-1:0]            quo,
   output logic [plu_pkg::CNT_W-1:0]           rem
);

   localparam int CW  = plu_pkg::CNT_W;
   localparam int CNT_BITS = $clog2(DATA_W + 1);

   logic                run_ff, run_in;
   logic                fix_ff, fix_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]   shift_ff, shift_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       den_ff, den_in;
   logic                sign_ff, sign_in;

   logic [CW:0]         rem_try;
   logic                fits;

   always_comb begin
      rem_try = {rem_ff, shift_ff[DATA_W-1]};
      fits    = rem_try >= {1'b0, den_ff};
   end

   always_comb begin
      run_in   = run_ff;
      fix_in   = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      sign_in  = sign_ff;
      if (go) begin
         run_in   = 1'b1;
         cnt_in   = CNT_BITS'(DATA_W);
         sign_in  = num[DATA_W-1];
         shift_in = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
         rem_in   = '0;
         den_in   = den;
      end else if (run_ff) begin
         // one quotient bit per cycle
         shift_in = {shift_ff[DATA_W-2:0], fits};
         rem_in   = fits ? CW'(rem_try - {1'b0, den_ff}) : rem_try[CW-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in = 1'b0;
            fix_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fix_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fix_ff <= fix_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      sign_ff  <= sign_in;
   end

   // turn truncated magnitude result into floor quotient and positive remainder
   always_comb begin
      done = fix_ff;
      if (!sign_ff) begin
         quo = shift_ff;
         rem = rem_ff;
      end else if (rem_ff == '0) begin
         quo = -shift_ff;
         rem = '0;
      end else begin
         quo = ~shift_ff;
         rem = den_ff - rem_ff;
      end
   end

endmodule

`default_nettype wire

>>> hdl/polyline_linear_upsampler_core.sv
`default_nettype none

// Linear upsampler for the node values of a polyline.
// Request channel (req_): one node word per item, with last_node marking
// the final node and closed (read on the last node) selecting a wrap back
// to the first node. Response channel (rsp_): one value word per cycle at
// most, run_last on the final word of an item, poly_end on the final word
// of the polyline. csr_wr_en/csr_wr_data set the interior count (4 after reset).
// Each segment first runs a bit-serial floor divider of the segment delta
// by the interior count plus one, then emits the interior count plus one
// words, one per cycle while rsp_ is not stalled, by stepping quotient and
// remainder. A closed last node adds a second segment and one more word.
// The first node of a polyline that is not its last gives no word and
// leaves the sequencer idle.
// req_stall is high while an item is in work. A stall on rsp_ holds the
// output valid and data and pauses the sequencer in its emit and closing
// states; the next item is accepted while the final word still waits.
// Reset clears the sequencer, the output valid flag and the polyline start
// flag, and sets the interior count to 4.
module polyline_linear_upsampler_core #(
   parameter int VALUE_BITS = plu_pkg::VALUE_BITS_DEF,
   parameter int MAX_ADDED  = plu_pkg::MAX_ADDED_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [VALUE_BITS-1:0]      req_node_value,
   input  wire logic                              req_last_node,
   input  wire logic                              req_closed,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [VALUE_BITS-1:0]           rsp_out_value,
   output logic                                   rsp_run_last,
   output logic                                   rsp_poly_end,
   input  wire logic                              csr_wr_en,
   input  wire logic [plu_pkg::CNT_W-1:0]         csr_wr_data
);

   localparam int CW = plu_pkg::CNT_W;
   localparam int DW = VALUE_BITS + 1;

   plu_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                added_ff;
   logic                         have_prev_ff, have_prev_in;
   logic signed [VALUE_BITS-1:0] first_ff, prev_ff, value_ff;
   logic                         last_ff, closed_ff, wrap_ff;
   logic signed [VALUE_BITS-1:0] seg_start_ff;
   logic signed [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [CW-1:0]                frac_ff, frac_in;
   logic [CW-1:0]                cnt_ff;
   logic signed [DW-1:0]         step_q_ff;
   logic [CW-1:0]                step_r_ff;

   logic                         rsp_valid_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;
   logic                         rsp_run_last_ff, rsp_poly_end_ff;

   logic [CW-1:0]                n_sat, den;
   logic                         req_fire, out_free, seg_done;
   logic                         div_go, emit_load, wrap_in;
   logic signed [VALUE_BITS-1:0] seg_start_in, seg_end_in;
   logic signed [DW-1:0]         delta;
   logic                         div_done;
   logic signed [DW-1:0]         div_quo;
   logic [CW-1:0]                div_rem;
   logic [CW:0]                  frac_sum;
   logic                         carry;
   logic signed [DW-1:0]         cur_sum;
   logic signed [VALUE_BITS-1:0] out_value_c;
   logic                         out_run_last_c, out_poly_end_c;

   always_comb begin
      n_sat    = (added_ff > CW'(MAX_ADDED)) ? CW'(MAX_ADDED) : added_ff;
      den      = n_sat + 1'b1;
      req_fire = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
      seg_done = out_free && (cnt_ff == n_sat);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plu_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (have_prev_ff) begin
                  state_in = plu_pkg::ST_DIV;
               end else if (req_last_node) begin
                  state_in = req_closed ? plu_pkg::ST_DIV : plu_pkg::ST_TAIL;
               end
            end
         end
         plu_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = plu_pkg::ST_EMIT;
            end
         end
         plu_pkg::ST_EMIT: begin
            if (seg_done) begin
               if (wrap_ff) begin
                  state_in = plu_pkg::ST_TAIL;
               end else if (last_ff) begin
                  state_in = closed_ff ? plu_pkg::ST_DIV : plu_pkg::ST_TAIL;
               end else begin
                  state_in = plu_pkg::ST_IDLE;
               end
            end
         end
         plu_pkg::ST_TAIL: begin
            if (out_free) begin
               state_in = plu_pkg::ST_IDLE;
            end
         end
         default: state_in = plu_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall      = 1'b1;
      div_go         = 1'b0;
      emit_load      = 1'b0;
      wrap_in        = wrap_ff;
      seg_start_in   = req_node_value;
      seg_end_in     = req_node_value;
      out_value_c    = cur_ff;
      out_run_last_c = 1'b0;
      out_poly_end_c = 1'b0;
      unique case (state_ff)
         plu_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (have_prev_ff) begin
               seg_start_in = prev_ff;
               wrap_in      = 1'b0;
               div_go       = req_fire;
            end else begin
               // single-node closed polyline wraps onto itself
               wrap_in = 1'b1;
               div_go  = req_fire && req_last_node && req_closed;
            end
         end
         plu_pkg::ST_DIV: begin
         end
         plu_pkg::ST_EMIT: begin
            emit_load      = out_free;
            out_run_last_c = (cnt_ff == n_sat) && !last_ff;
            seg_start_in   = value_ff;
            seg_end_in     = first_ff;
            wrap_in        = 1'b1;
            div_go         = seg_done && !wrap_ff && last_ff && closed_ff;
         end
         plu_pkg::ST_TAIL: begin
            emit_load      = out_free;
            out_value_c    = closed_ff ? first_ff : value_ff;
            out_run_last_c = 1'b1;
            out_poly_end_c = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      delta = {seg_end_in[VALUE_BITS-1], seg_end_in}
            - {seg_start_in[VALUE_BITS-1], seg_start_in};
   end

   plu_floor_div #(
      .DATA_W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (delta),
      .den   (den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // step to the next interior point: q += Q, r += R with carry at den
   always_comb begin
      frac_sum = {1'b0, frac_ff} + {1'b0, step_r_ff};
      carry    = frac_sum >= {1'b0, den};
      frac_in  = carry ? CW'(frac_sum - {1'b0, den}) : frac_sum[CW-1:0];
      cur_sum  = {cur_ff[VALUE_BITS-1], cur_ff} + step_q_ff
               + {{(DW-1){1'b0}}, carry};
      cur_in   = cur_sum[VALUE_BITS-1:0];
   end

   always_comb begin
      have_prev_in = have_prev_ff;
      if (req_fire) begin
         have_prev_in = !req_last_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plu_pkg::ST_IDLE;
         have_prev_ff <= 1'b0;
         added_ff     <= plu_pkg::ADDED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         if (csr_wr_en) begin
            added_ff <= csr_wr_data;
         end
         rsp_valid_ff <= emit_load || (rsp_valid_ff && rsp_stall);
      end

      if (req_fire) begin
         if (!have_prev_ff) begin
            first_ff <= req_node_value;
         end
         prev_ff   <= req_node_value;
         value_ff  <= req_node_value;
         last_ff   <= req_last_node;
         closed_ff <= req_closed;
      end

      if (div_go) begin
         seg_start_ff <= seg_start_in;
         wrap_ff      <= wrap_in;
      end

      if (div_done) begin
         step_q_ff <= div_quo;
         step_r_ff <= div_rem;
         cur_ff    <= seg_start_ff;
         frac_ff   <= '0;
         cnt_ff    <= '0;
      end else if (state_ff == plu_pkg::ST_EMIT && out_free) begin
         cur_ff  <= cur_in;
         frac_ff <= frac_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end

      if (emit_load) begin
         rsp_value_ff    <= out_value_c;
         rsp_run_last_ff <= out_run_last_c;
         rsp_poly_end_ff <= out_poly_end_c;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_poly_end  = rsp_poly_end_ff;

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == plu_pkg::ST_EMIT |-> cnt_ff <= n_sat)
      else $error("interior counter ran past the interior count");

   a_frac_below_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == plu_pkg::ST_EMIT |-> frac_ff < den)
      else $error("step remainder not below divisor");

   a_tail_on_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == plu_pkg::ST_TAIL |-> last_ff)
      else $error("closing word without a last node");

   a_wrap_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plu_pkg::ST_EMIT && wrap_ff) |-> (last_ff && closed_ff))
      else $error("wrap segment on an open or unfinished polyline");

   a_new_polyline: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last_node) |=> !have_prev_ff)
      else $error("polyline start flag kept after last node");

endmodule

`default_nettype wire

>>> dv/upsample_checker.sv
`timescale 1ns / 100ps

module upsample_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic signed [plu_pkg::VALUE_BITS_DEF-1:0] req_node_value,
   input  wire logic                               req_last_node,
   input  wire logic                               req_closed,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic signed [plu_pkg::VALUE_BITS_DEF-1:0] rsp_out_value,
   input  wire logic                               rsp_run_last,
   input  wire logic                               rsp_poly_end,
   input  wire logic                               csr_wr_en,
   input  wire logic [plu_pkg::CNT_W-1:0]          csr_wr_data,
   output int                                      mismatches,
   output int                                      words_owed
);

   localparam int VW        = plu_pkg::VALUE_BITS_DEF;
   localparam int MAX_ADDED = plu_pkg::MAX_ADDED_DEF;

   typedef struct {
      logic signed [VW-1:0] value;
      logic                 run_last;
      logic                 poly_end;
   } value_word_type;

   value_word_type expected_words[$];

   logic [plu_pkg::CNT_W-1:0] interior_cnt;
   logic signed [VW-1:0]      first_node;
   logic signed [VW-1:0]      prev_node;
   bit                        have_prev;

   // quotient rounded toward minus infinity
   function automatic int floor_quot(int num, int den);
      int q;
      q = num / den;
      if (num % den != 0 && num < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   task automatic push_value(int v);
      value_word_type w;
      w.value    = VW'(v);
      w.run_last = 1'b0;
      w.poly_end = 1'b0;
      expected_words.push_back(w);
   endtask

   // start value plus the interior points, the end value belongs to the next segment
   task automatic push_segment(int from, int to, int n);
      int j;
      push_value(from);
      for (j = 1; j <= n; j++) begin
         push_value(from + floor_quot((to - from) * j, n + 1));
      end
   endtask

   task automatic expand_node(logic signed [VW-1:0] node, logic last, logic closed);
      int             n;
      int             base;
      value_word_type w;
      base = expected_words.size();
      n = int'(interior_cnt);
      if (n > MAX_ADDED) begin
         n = MAX_ADDED;
      end
      if (have_prev) begin
         push_segment(prev_node, node, n);
      end else begin
         first_node = node;
         have_prev  = 1'b1;
      end
      prev_node = node;
      if (last) begin
         if (closed) begin
            push_segment(node, first_node, n);
            push_value(first_node);
         end else begin
            push_value(node);
         end
         w = expected_words.pop_back();
         w.poly_end = 1'b1;
         expected_words.push_back(w);
         have_prev = 1'b0;
      end
      if (expected_words.size() > base) begin
         w = expected_words.pop_back();
         w.run_last = 1'b1;
         expected_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin : watch
      value_word_type want;
      if (reset) begin
         interior_cnt = plu_pkg::ADDED_RESET;
         first_node   = '0;
         prev_node    = '0;
         have_prev    = 1'b0;
         mismatches   = 0;
         expected_words.delete();
      end else begin
         // a word leaving now was issued before any node taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got value %0d",
                        $time, rsp_out_value);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_out_value !== want.value) begin
                  $display("%0t: out_value expected %0d got %0d",
                           $time, want.value, rsp_out_value);
                  mismatches++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $display("%0t: run_last expected %0b got %0b",
                           $time, want.run_last, rsp_run_last);
                  mismatches++;
               end
               if (rsp_poly_end !== want.poly_end) begin
                  $display("%0t: poly_end expected %0b got %0b",
                           $time, want.poly_end, rsp_poly_end);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) begin
            interior_cnt = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            expand_node(req_node_value, req_last_node, req_closed);
         end
      end
      words_owed = expected_words.size();
   end

endmodule

>>> dv/polyline_linear_upsampler_core_tb.sv
`timescale 1ns / 100ps

module polyline_linear_upsampler_core_tb;

   localparam int VW            = plu_pkg::VALUE_BITS_DEF;
   localparam int CW            = plu_pkg::CNT_W;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_AT_WORD  = 110;
   localparam int HOLD_CYCLES   = 300;

   localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [VW-1:0] req_node_value;
   logic                 req_last_node;
   logic                 req_closed;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [VW-1:0] rsp_out_value;
   logic                 rsp_run_last;
   logic                 rsp_poly_end;
   logic                 csr_wr_en;
   logic [CW-1:0]        csr_wr_data;

   int fail_count;
   int words_owed;
   bit req_idle_on;
   bit rsp_idle_on;

   polyline_linear_upsampler_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_node_value (req_node_value),
      .req_last_node  (req_last_node),
      .req_closed     (req_closed),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_run_last   (rsp_run_last),
      .rsp_poly_end   (rsp_poly_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   upsample_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_node_value (req_node_value),
      .req_last_node  (req_last_node),
      .req_closed     (req_closed),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_run_last   (rsp_run_last),
      .rsp_poly_end   (rsp_poly_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatches     (fail_count),
      .words_owed     (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("polyline_linear_upsampler_core: mismatch");
      $finish;
   end

   // receiver: random stall before each word when enabled, one long hold-off to back up the input
   initial begin : rsp_side
      int gap;
      int taken;
      taken = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_idle_on ? int'($urandom_range(0, 8)) : 0;
         if (taken == HOLD_AT_WORD) begin
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   task automatic send_node(input logic signed [VW-1:0] v, input logic last,
                            input logic closed);
      int gap;
      gap = req_idle_on ? int'($urandom_range(0, 8)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_node_value <= v;
      req_last_node  <= last;
      req_closed     <= closed;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // wait for every word owed, then let a node that gives no word finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_added(input int count);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CW'(count);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic signed [VW-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return V_MAX;
         1:       return V_MIN;
         2, 3:    return VW'(int'($urandom_range(0, 64)) - 32);
         default: return VW'($urandom());
      endcase
   endfunction

   task automatic send_polyline(input int len);
      int  k;
      logic closed;
      closed = 1'($urandom_range(0, 1));
      for (k = 0; k < len; k++) begin
         if (k == len - 1) begin
            send_node(pick_value(), 1'b1, closed);
         end else begin
            send_node(pick_value(), 1'b0, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin : stimulus
      int p;
      int cfg;
      int budget;
      int sent;
      int len;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_node_value <= '0;
      req_last_node  <= 1'b0;
      req_closed     <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // four added points out of reset
      send_node(V_MAX, 1'b1, 1'b0);
      send_node(V_MIN, 1'b1, 1'b1);
      send_node(V_MIN, 1'b0, 1'b1);
      send_node(V_MAX, 1'b1, 1'b0);
      send_node(V_MAX, 1'b0, 1'b0);
      send_node(V_MIN, 1'b1, 1'b0);
      send_node(VW'(0), 1'b0, 1'b0);
      send_node(VW'(-1), 1'b0, 1'b1);
      send_node(VW'(256), 1'b1, 1'b1);

      // no interior points
      set_added(0);
      send_node(VW'(5), 1'b0, 1'b0);
      send_node(VW'(-5), 1'b1, 1'b1);
      send_node(VW'(0), 1'b1, 1'b1);
      send_node(V_MIN, 1'b1, 1'b0);

      // above the maximum, saturates
      set_added(31);
      send_node(V_MIN, 1'b0, 1'b0);
      send_node(V_MAX, 1'b1, 1'b1);

      set_added(30);
      send_node(VW'(1), 1'b0, 1'b0);
      send_node(VW'(0), 1'b0, 1'b0);
      send_node(VW'(-2), 1'b1, 1'b0);

      for (p = 0; p < 8; p++) begin
         case (p)
            0:       begin cfg = 30; budget = 12; end
            1:       begin cfg = 0; budget = 30; end
            2:       begin cfg = 31; budget = 12; end
            3:       begin cfg = 2; budget = 30; end
            6:       begin cfg = int'($urandom_range(0, 31)); budget = 14; end
            7:       begin cfg = 4; budget = 30; end
            default: begin cfg = int'($urandom_range(0, 7)); budget = 30; end
         endcase
         set_added(cfg);
         req_idle_on = (p % 4) != 3;
         rsp_idle_on = (p % 3) != 2;
         sent = 0;
         while (sent < budget) begin
            len = int'($urandom_range(1, 6));
            send_polyline(len);
            sent += len;
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("polyline_linear_upsampler_core: match");
      end else begin
         $display("polyline_linear_upsampler_core: mismatch");
      end
      $finish;
   end

endmodule
